/* hw/rtl/jtagdtm_pkg.sv */
// ----------------------------------------------------------------------------
// jtagdtm_pkg
// Shared constants, codes and the TAP next-state function for the JTAG TAP
// with debug transport.
// ----------------------------------------------------------------------------
package jtagdtm_pkg;

  localparam int DEF_ADDR_BITS = 6;
  localparam int DEF_IR_LEN    = 5;

  localparam logic [31:0] DEF_ID_CODE  = 32'hdeadbeef;
  localparam logic [31:0] DEF_DTM_CTRL = 32'h00000061;

  // Input item kinds (tuser).
  localparam logic [1:0] FUNC_PIN       = 2'd0;
  localparam logic [1:0] FUNC_RESP      = 2'd1;
  localparam logic [1:0] FUNC_TAP_RESET = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_ID_CODE  = 1'b0;
  localparam logic CFG_DTM_CTRL = 1'b1;

  // Instruction codes.
  localparam logic [4:0] INS_IDCODE = 5'h01;
  localparam logic [4:0] INS_DTMCS  = 5'h10;
  localparam logic [4:0] INS_DMI    = 5'h11;

  // DMI op field.
  localparam logic [1:0] OP_NOP     = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_WRITE   = 2'd2;
  localparam logic [1:0] OP_SUCCESS = 2'd0;
  localparam logic [1:0] OP_FAILED  = 2'd2;

  // TAP states.
  localparam logic [3:0] TAP_RESET      = 4'd0;
  localparam logic [3:0] TAP_IDLE       = 4'd1;
  localparam logic [3:0] TAP_SELECT_DR  = 4'd2;
  localparam logic [3:0] TAP_CAPTURE_DR = 4'd3;
  localparam logic [3:0] TAP_SHIFT_DR   = 4'd4;
  localparam logic [3:0] TAP_EXIT1_DR   = 4'd5;
  localparam logic [3:0] TAP_PAUSE_DR   = 4'd6;
  localparam logic [3:0] TAP_EXIT2_DR   = 4'd7;
  localparam logic [3:0] TAP_UPDATE_DR  = 4'd8;
  localparam logic [3:0] TAP_SELECT_IR  = 4'd9;
  localparam logic [3:0] TAP_CAPTURE_IR = 4'd10;
  localparam logic [3:0] TAP_SHIFT_IR   = 4'd11;
  localparam logic [3:0] TAP_EXIT1_IR   = 4'd12;
  localparam logic [3:0] TAP_PAUSE_IR   = 4'd13;
  localparam logic [3:0] TAP_EXIT2_IR   = 4'd14;
  localparam logic [3:0] TAP_UPDATE_IR  = 4'd15;

  function automatic logic [3:0] tap_step(input logic [3:0] s, input logic tms);
    logic [3:0] n;
    case (s)
      TAP_RESET:      n = tms ? TAP_RESET     : TAP_IDLE;
      TAP_IDLE:       n = tms ? TAP_SELECT_DR : TAP_IDLE;
      TAP_SELECT_DR:  n = tms ? TAP_SELECT_IR : TAP_CAPTURE_DR;
      TAP_CAPTURE_DR: n = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
      TAP_SHIFT_DR:   n = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
      TAP_EXIT1_DR:   n = tms ? TAP_UPDATE_DR : TAP_PAUSE_DR;
      TAP_PAUSE_DR:   n = tms ? TAP_EXIT2_DR  : TAP_PAUSE_DR;
      TAP_EXIT2_DR:   n = tms ? TAP_UPDATE_DR : TAP_SHIFT_DR;
      TAP_UPDATE_DR:  n = tms ? TAP_SELECT_DR : TAP_IDLE;
      TAP_SELECT_IR:  n = tms ? TAP_RESET     : TAP_CAPTURE_IR;
      TAP_CAPTURE_IR: n = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
      TAP_SHIFT_IR:   n = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
      TAP_EXIT1_IR:   n = tms ? TAP_UPDATE_IR : TAP_PAUSE_IR;
      TAP_PAUSE_IR:   n = tms ? TAP_EXIT2_IR  : TAP_PAUSE_IR;
      TAP_EXIT2_IR:   n = tms ? TAP_UPDATE_IR : TAP_SHIFT_IR;
      TAP_UPDATE_IR:  n = tms ? TAP_SELECT_DR : TAP_IDLE;
      default:        n = TAP_RESET;
    endcase
    return n;
  endfunction

endpackage

/* hw/rtl/jtag_tap_with_debug_transport_core.sv */
// ----------------------------------------------------------------------------
// jtag_tap_with_debug_transport_core
// JTAG TAP with an IR_LEN-bit IR (default 5) and a debug module interface transport.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// s_axis    in         tvalid/tready         tuser: func; tdata: pins, response
// m_axis    out        tvalid/tready         tdata: tdo, TAP state, DMI request
// cfg       in         cfg_we (no wait)      cfg_index, cfg_data
//
// One item per clock is sustained while m_axis takes results; the result of an item
// passes the input register, then the result register, before it is offered on m_axis.
// The whole TAP and DMI update for an item is done in the cycle in which it
// leaves the input register, so the next item sees the new state at once.
// A stall on m_axis holds both registers; s_axis_tready stays high while the
// input register is empty or moving on.
// rst is synchronous and returns the TAP to Test-Logic-Reset with empty stages.
// ----------------------------------------------------------------------------
module jtag_tap_with_debug_transport_core
  import jtagdtm_pkg::*;
#(
  parameter int ADDR_BITS = DEF_ADDR_BITS,
  parameter int IR_LEN    = DEF_IR_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // func
  input  logic [39:0] s_axis_tdata,   // tck, tms, tdi, resp_data[31:0], resp_ok, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // tdo, tap_now[3:0], dmi_req_valid,
                                      // dmi_req_write, dmi_req_addr[5:0],
                                      // dmi_req_wdata[31:0], pad
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int DR_W = ADDR_BITS + 34;

  logic [31:0] id_code;
  logic [31:0] dtm_ctrl;

  logic        in_valid;
  logic [1:0]  in_func;
  logic        in_tck;
  logic        in_tms;
  logic        in_tdi;
  logic [31:0] in_resp_data;
  logic        in_resp_ok;

  logic             prev_tck, prev_tck_next;
  logic             prev_tms, prev_tms_next;
  logic             prev_tdi, prev_tdi_next;
  logic [3:0]       tap_state, tap_state_next;
  logic [IR_LEN-1:0] instr_reg, instr_reg_next;
  logic [DR_W-1:0]  data_reg, data_reg_next;
  logic             long_scan, long_scan_next;
  logic             tdo_bit, tdo_bit_next;
  logic [DR_W-1:0]  dmi_reg, dmi_reg_next;
  logic             read_pending, read_pending_next;

  logic        req_valid;
  logic        req_write;
  logic [5:0]  req_addr;
  logic [31:0] req_wdata;

  logic        out_valid;
  logic [47:0] out_data;
  logic        advance;

  logic [DR_W-1:0]       dr_shift;
  logic [1:0]            dr_op;
  logic [ADDR_BITS+5:0]  addr_ext;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_code  <= DEF_ID_CODE;
      dtm_ctrl <= DEF_DTM_CTRL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ID_CODE:  id_code  <= cfg_data;
        CFG_DTM_CTRL: dtm_ctrl <= cfg_data;
        default:      id_code  <= id_code;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func      <= s_axis_tuser;
      in_tck       <= s_axis_tdata[0];
      in_tms       <= s_axis_tdata[1];
      in_tdi       <= s_axis_tdata[2];
      in_resp_data <= s_axis_tdata[34:3];
      in_resp_ok   <= s_axis_tdata[35];
    end
  end

  always_comb begin
    dr_shift = data_reg >> 1;
    if (long_scan) begin
      dr_shift[DR_W-1] = dr_shift[DR_W-1] | prev_tdi;
    end else begin
      dr_shift[31] = dr_shift[31] | prev_tdi;
    end
  end

  always_comb begin
    prev_tck_next     = prev_tck;
    prev_tms_next     = prev_tms;
    prev_tdi_next     = prev_tdi;
    tap_state_next    = tap_state;
    instr_reg_next    = instr_reg;
    data_reg_next     = data_reg;
    long_scan_next    = long_scan;
    tdo_bit_next      = tdo_bit;
    dmi_reg_next      = dmi_reg;
    read_pending_next = read_pending;
    req_valid         = 1'b0;
    req_write         = 1'b0;
    req_addr          = 6'd0;
    req_wdata         = 32'd0;
    dr_op             = 2'd0;
    addr_ext          = '0;
    case (in_func)
      FUNC_PIN: begin
        if (!prev_tck && in_tck) begin
          if (tap_state == TAP_SHIFT_DR) begin
            data_reg_next = dr_shift;
          end else if (tap_state == TAP_SHIFT_IR) begin
            instr_reg_next = {prev_tdi, instr_reg[IR_LEN-1:1]};
          end
          tap_state_next = tap_step(tap_state, prev_tms);
          if (tap_state_next == TAP_RESET) begin
            instr_reg_next = IR_LEN'(INS_IDCODE);
          end else if (tap_state_next == TAP_CAPTURE_DR) begin
            if (instr_reg_next == IR_LEN'(INS_IDCODE)) begin
              data_reg_next  = {{(DR_W-32){1'b0}}, id_code};
              long_scan_next = 1'b0;
            end else if (instr_reg_next == IR_LEN'(INS_DTMCS)) begin
              data_reg_next  = {{(DR_W-32){1'b0}}, dtm_ctrl};
              long_scan_next = 1'b0;
            end else if (instr_reg_next == IR_LEN'(INS_DMI)) begin
              data_reg_next  = dmi_reg;
              long_scan_next = 1'b1;
            end
          end else if (tap_state_next == TAP_SHIFT_DR) begin
            tdo_bit_next = data_reg_next[0];
          end else if (tap_state_next == TAP_SHIFT_IR) begin
            tdo_bit_next = instr_reg_next[0];
          end else if (tap_state_next == TAP_UPDATE_DR &&
                       instr_reg_next == IR_LEN'(INS_DMI)) begin
            dr_op        = data_reg_next[1:0];
            dmi_reg_next = data_reg_next;
            if (dr_op == OP_READ || dr_op == OP_WRITE) begin
              addr_ext          = {6'd0, data_reg_next[DR_W-1:34]};
              req_valid         = 1'b1;
              req_write         = (dr_op == OP_WRITE);
              req_addr          = addr_ext[5:0];
              req_wdata         = data_reg_next[33:2];
              read_pending_next = (dr_op == OP_READ);
            end else begin
              dmi_reg_next[1:0] = OP_SUCCESS;
            end
          end
        end
        prev_tck_next = in_tck;
        prev_tms_next = in_tms;
        prev_tdi_next = in_tdi;
      end
      FUNC_RESP: begin
        if (read_pending && in_resp_ok) begin
          dmi_reg_next[33:2] = in_resp_data;
        end
        dmi_reg_next[1:0] = in_resp_ok ? OP_SUCCESS : OP_FAILED;
        read_pending_next = 1'b0;
      end
      FUNC_TAP_RESET: begin
        tap_state_next = TAP_RESET;
      end
      default: begin
        tap_state_next = tap_state;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_tck     <= 1'b0;
      prev_tms     <= 1'b0;
      prev_tdi     <= 1'b0;
      tap_state    <= TAP_RESET;
      instr_reg    <= '0;
      data_reg     <= '0;
      long_scan    <= 1'b0;
      tdo_bit      <= 1'b0;
      dmi_reg      <= {{(DR_W-2){1'b0}}, OP_FAILED};
      read_pending <= 1'b0;
    end else if (advance) begin
      prev_tck     <= prev_tck_next;
      prev_tms     <= prev_tms_next;
      prev_tdi     <= prev_tdi_next;
      tap_state    <= tap_state_next;
      instr_reg    <= instr_reg_next;
      data_reg     <= data_reg_next;
      long_scan    <= long_scan_next;
      tdo_bit      <= tdo_bit_next;
      dmi_reg      <= dmi_reg_next;
      read_pending <= read_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {3'd0, req_wdata, req_addr, req_write, req_valid,
                   tap_state_next, tdo_bit_next};
    end
  end

endmodule

/* hw/rtl/jtagdtm_checker.sv */
// ----------------------------------------------------------------------------
// jtagdtm_checker
// Port-level checks for the JTAG TAP with debug transport, bound to the core.
// ----------------------------------------------------------------------------
module jtagdtm_checker
  import jtagdtm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // A request item must come from the Update-DR step.
  a_req_in_update: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[5]) |-> (m_axis_tdata[4:1] == TAP_UPDATE_DR))
    else $error("DMI request outside Update-DR");

  // Request fields are zero when no request is issued.
  a_req_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[5]) |-> (m_axis_tdata[44:6] == 39'd0))
    else $error("DMI request fields set without a request");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // An item accepted into an empty block must pass the input register first.
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !m_axis_tvalid && $past(!s_axis_tvalid || !s_axis_tready))
    |=> !m_axis_tvalid)
    else $error("item reached the output too early");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind jtag_tap_with_debug_transport_core jtagdtm_checker u_jtagdtm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the JTAG TAP with debug transport. Stimulus is built
// from JTAG clock sequences (IR and DR scans, DMI accesses, pauses, pin noise),
// debug bus responses and TAP resets, sent in bursts with random gaps. Each
// accepted item is run through a behavioral copy of the TAP and DMI logic, and
// every output item is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import jtagdtm_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int NUM_PHASES = 5;
  // The last sequence of a phase runs past the budget by about fifty items.
  localparam int PHASE_ITEMS = 1550 / NUM_PHASES - 50;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0]  func;
    logic        tck;
    logic        tms;
    logic        tdi;
    logic [31:0] resp_data;
    logic        resp_ok;
  } jtag_item_t;

  typedef struct packed {
    logic        tdo;
    logic [3:0]  tap_now;
    logic        req_valid;
    logic        req_write;
    logic [5:0]  req_addr;
    logic [31:0] req_wdata;
  } dtm_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = '0;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  jtag_item_t jtag_item_q[$];
  dtm_out_t   tap_outputs_q[$];
  int         errors = 0;
  int         results_seen = 0;

  // Behavioral TAP and DMI state, starting at the reset values.
  logic [31:0] cap_id_code = DEF_ID_CODE;
  logic [31:0] cap_dtm_ctrl = DEF_DTM_CTRL;
  logic        last_tck = 1'b0;
  logic        last_tms = 1'b0;
  logic        last_tdi = 1'b0;
  logic [3:0]  tap_cur = TAP_RESET;
  logic [4:0]  ir_shift = '0;
  logic [39:0] dr_shift = '0;
  logic        dr_wide = 1'b0;
  logic        tdo_level = 1'b0;
  logic [39:0] dmi_hold = 40'd2;
  logic        read_busy = 1'b0;

  // Stimulus generator view of the TAP.
  logic        gen_idle = 1'b0;
  logic [4:0]  gen_ir = INS_IDCODE;
  int          phase_items = 0;

  logic        item_taken = 1'b0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          rx_cycle = 0;
  int          rx_mode = 0;
  int          hold_left = 0;
  int          next_hold_at = 500;

  jtag_tap_with_debug_transport_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tuser  (s_tuser),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [3:0] tap_next_state(input logic [3:0] s, input logic tms);
    case (s)
      TAP_RESET:      return tms ? TAP_RESET     : TAP_IDLE;
      TAP_IDLE:       return tms ? TAP_SELECT_DR : TAP_IDLE;
      TAP_SELECT_DR:  return tms ? TAP_SELECT_IR : TAP_CAPTURE_DR;
      TAP_CAPTURE_DR: return tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
      TAP_SHIFT_DR:   return tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
      TAP_EXIT1_DR:   return tms ? TAP_UPDATE_DR : TAP_PAUSE_DR;
      TAP_PAUSE_DR:   return tms ? TAP_EXIT2_DR  : TAP_PAUSE_DR;
      TAP_EXIT2_DR:   return tms ? TAP_UPDATE_DR : TAP_SHIFT_DR;
      TAP_UPDATE_DR:  return tms ? TAP_SELECT_DR : TAP_IDLE;
      TAP_SELECT_IR:  return tms ? TAP_RESET     : TAP_CAPTURE_IR;
      TAP_CAPTURE_IR: return tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
      TAP_SHIFT_IR:   return tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
      TAP_EXIT1_IR:   return tms ? TAP_UPDATE_IR : TAP_PAUSE_IR;
      TAP_PAUSE_IR:   return tms ? TAP_EXIT2_IR  : TAP_PAUSE_IR;
      TAP_EXIT2_IR:   return tms ? TAP_UPDATE_IR : TAP_SHIFT_IR;
      default:        return tms ? TAP_SELECT_DR : TAP_IDLE;
    endcase
  endfunction

  task automatic step_dtm_model(input jtag_item_t it, output dtm_out_t res);
    logic [1:0] op;
    res = '0;
    case (it.func)
      FUNC_PIN: begin
        if (!last_tck && it.tck) begin
          if (tap_cur == TAP_SHIFT_DR) begin
            dr_shift = (dr_shift >> 1) | (40'(last_tdi) << (dr_wide ? 39 : 31));
          end else if (tap_cur == TAP_SHIFT_IR) begin
            ir_shift = {last_tdi, ir_shift[4:1]};
          end
          tap_cur = tap_next_state(tap_cur, last_tms);
          if (tap_cur == TAP_RESET) begin
            ir_shift = INS_IDCODE;
          end else if (tap_cur == TAP_CAPTURE_DR) begin
            if (ir_shift == INS_IDCODE) begin
              dr_shift = 40'(cap_id_code);
              dr_wide = 1'b0;
            end else if (ir_shift == INS_DTMCS) begin
              dr_shift = 40'(cap_dtm_ctrl);
              dr_wide = 1'b0;
            end else if (ir_shift == INS_DMI) begin
              dr_shift = dmi_hold;
              dr_wide = 1'b1;
            end
          end else if (tap_cur == TAP_SHIFT_DR) begin
            tdo_level = dr_shift[0];
          end else if (tap_cur == TAP_SHIFT_IR) begin
            tdo_level = ir_shift[0];
          end else if (tap_cur == TAP_UPDATE_DR && ir_shift == INS_DMI) begin
            op = dr_shift[1:0];
            dmi_hold = dr_shift;
            if (op == OP_READ || op == OP_WRITE) begin
              res.req_valid = 1'b1;
              res.req_write = (op == OP_WRITE);
              res.req_addr = dr_shift[39:34];
              res.req_wdata = dr_shift[33:2];
              read_busy = (op == OP_READ);
            end else begin
              dmi_hold[1:0] = OP_SUCCESS;
            end
          end
        end
        last_tck = it.tck;
        last_tms = it.tms;
        last_tdi = it.tdi;
      end
      FUNC_RESP: begin
        if (read_busy && it.resp_ok) dmi_hold[33:2] = it.resp_data;
        dmi_hold[1:0] = it.resp_ok ? OP_SUCCESS : OP_FAILED;
        read_busy = 1'b0;
      end
      FUNC_TAP_RESET: begin
        tap_cur = TAP_RESET;
      end
      default: begin
      end
    endcase
    res.tdo = tdo_level;
    res.tap_now = tap_cur;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  task automatic queue_item(input logic [1:0] func, input logic tck, input logic tms,
                            input logic tdi, input logic [31:0] data, input logic ok);
    jtag_item_t it;
    it.func = func;
    it.tck = tck;
    it.tms = tms;
    it.tdi = tdi;
    it.resp_data = data;
    it.resp_ok = ok;
    jtag_item_q.push_back(it);
    phase_items++;
  endtask

  task automatic queue_pin(input logic tck, input logic tms, input logic tdi);
    queue_item(FUNC_PIN, tck, tms, tdi, $urandom, $urandom_range(0, 1));
  endtask

  // One JTAG clock: the low-phase item carries the tms and tdi that the
  // following rising edge acts on. Extra low or high items are harmless.
  task automatic jtag_clock(input logic tms, input logic tdi);
    if ($urandom_range(0, 9) == 0)
      queue_pin(1'b0, $urandom_range(0, 1), $urandom_range(0, 1));
    queue_pin(1'b0, tms, tdi);
    queue_pin(1'b1, $urandom_range(0, 1), $urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0)
      queue_pin(1'b1, $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  task automatic reach_idle();
    if (!gen_idle) begin
      repeat (5) jtag_clock(1'b1, $urandom_range(0, 1));
      jtag_clock(1'b0, $urandom_range(0, 1));
      gen_ir = INS_IDCODE;
      gen_idle = 1'b1;
    end
  endtask

  task automatic scan_ir(input logic [4:0] code);
    reach_idle();
    jtag_clock(1'b1, $urandom_range(0, 1));
    jtag_clock(1'b1, $urandom_range(0, 1));
    jtag_clock(1'b0, $urandom_range(0, 1));
    jtag_clock(1'b0, $urandom_range(0, 1));
    for (int i = 0; i < 5; i++) jtag_clock(i == 4, code[i]);
    jtag_clock(1'b1, $urandom_range(0, 1));
    jtag_clock(1'b0, $urandom_range(0, 1));
    gen_ir = code;
  endtask

  task automatic scan_dr(input logic [63:0] value, input int len);
    int pause_at;
    reach_idle();
    jtag_clock(1'b1, $urandom_range(0, 1));
    jtag_clock(1'b0, $urandom_range(0, 1));
    jtag_clock(1'b0, $urandom_range(0, 1));
    pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == pause_at && i != len - 1) begin
        // Leave the shift through Exit1, Pause and Exit2, then resume.
        jtag_clock(1'b1, value[i]);
        repeat ($urandom_range(1, 3)) jtag_clock(1'b0, $urandom_range(0, 1));
        jtag_clock(1'b1, $urandom_range(0, 1));
        jtag_clock(1'b0, $urandom_range(0, 1));
      end else begin
        jtag_clock(i == len - 1, value[i]);
      end
    end
    jtag_clock(1'b1, $urandom_range(0, 1));
    jtag_clock(1'b0, $urandom_range(0, 1));
  endtask

  task automatic dmi_access();
    logic [1:0]  op;
    logic [63:0] value;
    if (gen_ir != INS_DMI || !gen_idle) scan_ir(INS_DMI);
    op = $urandom_range(0, 3);
    value = {24'b0, 6'($urandom), $urandom, op};
    scan_dr(value, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 44) : 40);
    if ((op == OP_READ || op == OP_WRITE) && $urandom_range(0, 6) != 0)
      queue_item(FUNC_RESP, $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 1), $urandom, $urandom_range(0, 3) != 0);
  endtask

  task automatic random_sequence();
    int pick;
    logic [4:0] code;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      dmi_access();
    end else if (pick < 47) begin
      case ($urandom_range(0, 4))
        0: code = INS_IDCODE;
        1: code = INS_DTMCS;
        2, 3: code = INS_DMI;
        default: code = 5'($urandom);
      endcase
      scan_ir(code);
    end else if (pick < 60) begin
      scan_dr({$urandom, $urandom}, ($urandom_range(0, 7) == 0) ?
              $urandom_range(1, 44) : ((gen_ir == INS_DMI) ? 40 : 32));
    end else if (pick < 68) begin
      reach_idle();
      repeat ($urandom_range(1, 4)) jtag_clock(1'b0, $urandom_range(0, 1));
    end else if (pick < 76) begin
      repeat ($urandom_range(1, 8))
        queue_pin($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
      gen_idle = 1'b0;
    end else if (pick < 80) begin
      queue_item(FUNC_TAP_RESET, $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 1), $urandom, $urandom_range(0, 1));
      gen_idle = 1'b0;
    end else if (pick < 87) begin
      queue_item(FUNC_RESP, $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 1), $urandom, $urandom_range(0, 1));
    end else if (pick < 89) begin
      queue_item(FUNC_UNUSED, $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 1), $urandom, $urandom_range(0, 1));
    end else begin
      gen_idle = 1'b0;
      reach_idle();
    end
  endtask

  task automatic queue_directed();
    // Responses with nothing pending, at the data extremes, and an unused item kind.
    queue_item(FUNC_RESP, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b0);
    queue_item(FUNC_RESP, 1'b0, 1'b0, 1'b0, 32'hffff_ffff, 1'b1);
    queue_item(FUNC_UNUSED, 1'b1, 1'b1, 1'b1, 32'hffff_ffff, 1'b1);
    // Stay in Test-Logic-Reset, which loads IDCODE into IR.
    queue_item(FUNC_PIN, 1'b0, 1'b1, 1'b1, 32'hffff_ffff, 1'b1);
    queue_item(FUNC_PIN, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b0);
    // High to high is not a rising edge.
    queue_item(FUNC_PIN, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0);
    queue_item(FUNC_PIN, 1'b0, 1'b0, 1'b1, 32'h0000_0000, 1'b0);
    queue_item(FUNC_PIN, 1'b1, 1'b0, 1'b0, 32'hffff_ffff, 1'b1);
    queue_item(FUNC_TAP_RESET, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0);
    queue_item(FUNC_PIN, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0);
    queue_item(FUNC_PIN, 1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b0);
    queue_item(FUNC_PIN, 1'b0, 1'b1, 1'b1, 32'h0000_0000, 1'b0);
    queue_item(FUNC_PIN, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b0);
    queue_item(FUNC_PIN, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0);
    // Pin levels seen with a response are not sampled.
    queue_item(FUNC_RESP, 1'b0, 1'b0, 1'b0, 32'h1234_5678, 1'b1);
    queue_item(FUNC_PIN, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0);
    queue_item(FUNC_PIN, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0);
    queue_item(FUNC_TAP_RESET, 1'b1, 1'b1, 1'b1, 32'hffff_ffff, 1'b1);
    gen_idle = 1'b0;
  endtask

  task automatic write_cfg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_ID_CODE) cap_id_code = val;
    else cap_dtm_ctrl = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (jtag_item_q.size() != 0 || s_tvalid || tap_outputs_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : item_acceptor
    jtag_item_t it;
    dtm_out_t   res;
    if (!rst && s_tvalid && s_tready) begin
      it.func = s_tuser;
      it.tck = s_tdata[0];
      it.tms = s_tdata[1];
      it.tdi = s_tdata[2];
      it.resp_data = s_tdata[34:3];
      it.resp_ok = s_tdata[35];
      step_dtm_model(it, res);
      tap_outputs_q.push_back(res);
      item_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : item_driver
    jtag_item_t it;
    if (!rst && (!s_tvalid || item_taken)) begin
      if (gap_left != 0 || jtag_item_q.size() == 0) begin
        s_tvalid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        it = jtag_item_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= it.func;
        s_tdata <= {4'b0, it.resp_ok, it.resp_data, it.tdi, it.tms, it.tck};
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    item_taken = 1'b0;
  end

  always @(negedge clk) begin : result_receiver
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left == 0 && results_seen >= next_hold_at) begin
      hold_left = HOLD_CYCLES;
      next_hold_at += 650;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        2: m_tready <= ($urandom_range(0, 9) != 0);
        default: m_tready <= ((rx_cycle % 5) < 3);
      endcase
    end
  end

  always @(posedge clk) begin : result_monitor
    dtm_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (tap_outputs_q.size() == 0) begin
        $error("output item with no prediction waiting: %0h", m_tdata);
        errors++;
      end else begin
        want = tap_outputs_q.pop_front();
        check_field("tdo", want.tdo, m_tdata[0]);
        check_field("tap_now", want.tap_now, m_tdata[4:1]);
        check_field("dmi_req_valid", want.req_valid, m_tdata[5]);
        check_field("dmi_req_write", want.req_write, m_tdata[6]);
        check_field("dmi_req_addr", want.req_addr, m_tdata[12:7]);
        check_field("dmi_req_wdata", want.req_wdata, m_tdata[44:13]);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] id_val;
    logic [31:0] ctrl_val;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          id_val = DEF_ID_CODE;
          ctrl_val = DEF_DTM_CTRL;
        end
        1: begin
          id_val = 32'h0000_0000;
          ctrl_val = 32'h0000_0000;
        end
        2: begin
          id_val = 32'hffff_ffff;
          ctrl_val = 32'hffff_ffff;
        end
        default: begin
          id_val = $urandom;
          ctrl_val = $urandom;
        end
      endcase
      write_cfg(CFG_ID_CODE, id_val);
      write_cfg(CFG_DTM_CTRL, ctrl_val);
      if (phase == 0) queue_directed();
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) random_sequence();
      wait_for_drain();
    end
    repeat (10) @(posedge clk);
    if (tap_outputs_q.size() != 0) begin
      $error("%0d predicted output items never arrived", tap_outputs_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
